@@ rtl/fisr_pkg.sv @@
// Package for the fast inverse square root unit: constants and float helpers.
// Depends on nothing; used by fisr_fmul, fisr_fadd and the top level.
package fisr_pkg;

   localparam logic [31:0] SEED_MAGIC        = 32'h5f3759df;
   localparam logic [31:0] HALF_BITS         = 32'h3f000000;
   localparam logic [31:0] THREE_HALVES_BITS = 32'h3fc00000;
   localparam logic [31:0] QNAN_BITS         = 32'h7fc00000;

   // Cycles from the input register to the output register of the last multiplier.
   localparam int          LATENCY           = 15;

   function automatic logic f_is_nan(input logic [31:0] a);
      f_is_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
   endfunction

   function automatic logic f_is_inf(input logic [31:0] a);
      f_is_inf = (a[30:0] == 31'h7f800000);
   endfunction

   function automatic logic f_is_zero(input logic [31:0] a);
      f_is_zero = (a[30:0] == 31'd0);
   endfunction

   // Leading zero count of a 64-bit word (returns 64 for zero).
   function automatic logic [6:0] f_lzc64(input logic [63:0] v);
      logic [6:0] n;
      logic       found;
      n     = 7'd64;
      found = 1'b0;
      for (int i = 63; i >= 0; i--) begin
         if (!found && v[i]) begin
            n     = 7'(63 - i);
            found = 1'b1;
         end
      end
      f_lzc64 = n;
   endfunction

   // Round a significand with top bit at 62, value (m/2^62)*2^(e-127).
   function automatic logic [31:0] f_round_pack(input logic sign,
                                                input logic signed [11:0] e,
                                                input logic [63:0] m);
      logic [31:0] s;
      logic [11:0] sh;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      logic [31:0] bits;
      s    = {sign, 31'd0};
      sh   = (e <= 0) ? 12'(12'sd40 - e) : 12'd39;
      q    = 64'd0;
      rem  = 64'd0;
      half = 64'd0;
      bits = 32'd0;
      if (e >= 255) begin
         f_round_pack = s | 32'h7f800000;
      end else if (sh >= 12'd64) begin
         f_round_pack = s;
      end else begin
         q    = m >> sh[5:0];
         rem  = m & ((64'd1 << sh[5:0]) - 64'd1);
         half = 64'd1 << (sh[5:0] - 6'd1);
         if (rem > half || (rem == half && q[0])) begin
            q = q + 64'd1;
         end
         if (e <= 0) begin
            bits = q[31:0];
         end else begin
            bits = {9'(e - 12'sd1), 23'd0} + q[31:0];
         end
         if (bits >= 32'h7f800000) begin
            bits = 32'h7f800000;
         end
         f_round_pack = s | bits;
      end
   endfunction

endpackage

@@ rtl/fisr_fmul.sv @@
// Pipelined single-precision multiplier, three register stages.
// Depends on fisr_pkg.
module fisr_fmul
   import fisr_pkg::*;
(
   input  logic        clock,
   input  logic        enable,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] product
);

   // stage 1: unpack, normalize subnormals, special cases
   logic                special_in, special_ff;
   logic [31:0]         spec_val_in, spec_val_ff;
   logic                sign_in, sign_ff, sign2_ff;
   logic signed [11:0]  e_in, e_ff, e2_ff;
   logic [23:0]         ma_in, mb_in, ma_ff, mb_ff;
   logic                special2_ff;
   logic [31:0]         spec_val2_ff;
   logic [47:0]         p_ff;
   logic [31:0]         product_ff;
   logic [6:0]          lza, lzb;
   logic signed [11:0]  ea, eb;

   always_comb begin
      sign_in     = a[31] ^ b[31];
      special_in  = 1'b1;
      spec_val_in = {sign_in, 31'd0};
      lza = f_lzc64({40'd0, 1'b0, a[22:0]});
      lzb = f_lzc64({40'd0, 1'b0, b[22:0]});
      if (a[30:23] == 8'd0) begin
         ea    = 12'sd1 - 12'(lza - 7'd40);
         ma_in = 24'({1'b0, a[22:0]} << (lza - 7'd40));
      end else begin
         ea    = 12'(a[30:23]);
         ma_in = {1'b1, a[22:0]};
      end
      if (b[30:23] == 8'd0) begin
         eb    = 12'sd1 - 12'(lzb - 7'd40);
         mb_in = 24'({1'b0, b[22:0]} << (lzb - 7'd40));
      end else begin
         eb    = 12'(b[30:23]);
         mb_in = {1'b1, b[22:0]};
      end
      e_in = ea + eb - 12'sd127;
      if (f_is_nan(a) || f_is_nan(b)) begin
         spec_val_in = QNAN_BITS;
      end else if (f_is_inf(a) || f_is_inf(b)) begin
         spec_val_in = (f_is_zero(a) || f_is_zero(b)) ? QNAN_BITS
                                                      : {sign_in, 31'h7f800000};
      end else if (f_is_zero(a) || f_is_zero(b)) begin
         spec_val_in = {sign_in, 31'd0};
      end else begin
         special_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         special_ff   <= special_in;
         spec_val_ff  <= spec_val_in;
         sign_ff      <= sign_in;
         e_ff         <= e_in;
         ma_ff        <= ma_in;
         mb_ff        <= mb_in;
         // stage 2: 24x24 multiply
         special2_ff  <= special_ff;
         spec_val2_ff <= spec_val_ff;
         sign2_ff     <= sign_ff;
         e2_ff        <= e_ff;
         p_ff         <= ma_ff * mb_ff;
         product_ff   <= special2_ff ? spec_val2_ff
                         : (p_ff[47] ? f_round_pack(sign2_ff, e2_ff + 12'sd1,
                                                    {1'b0, p_ff, 15'd0})
                                     : f_round_pack(sign2_ff, e2_ff,
                                                    {p_ff, 16'd0}));
      end
   end

   assign product = product_ff;

endmodule

@@ rtl/fisr_fadd.sv @@
// Pipelined single-precision adder, three register stages.
// Depends on fisr_pkg.
module fisr_fadd
   import fisr_pkg::*;
(
   input  logic        clock,
   input  logic        enable,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] sum
);

   logic               special_in, special_ff, special2_ff;
   logic [31:0]        spec_in, spec_ff, spec2_ff;
   logic               s_in, s_ff, s2_ff;
   logic signed [11:0] e_in, e_ff, e2_ff;
   logic [63:0]        wa_in, wb_in, wa_ff, wb_ff;
   logic               sub_in, sub_ff;
   logic [63:0]        acc_ff;
   logic [31:0]        sum_ff;
   logic signed [11:0] ea, eb, te;
   logic [23:0]        ma, mb, tm;
   logic               sa, sb, ts;
   logic [6:0]         lza, lzb, lzs;
   logic [11:0]        d;
   logic [63:0]        nrm;

   always_comb begin
      sa = a[31];
      sb = b[31];
      lza = f_lzc64({40'd0, 1'b0, a[22:0]});
      lzb = f_lzc64({40'd0, 1'b0, b[22:0]});
      if (a[30:23] == 8'd0) begin
         ea = 12'sd1 - 12'(lza - 7'd40);
         ma = 24'({1'b0, a[22:0]} << (lza - 7'd40));
      end else begin
         ea = 12'(a[30:23]);
         ma = {1'b1, a[22:0]};
      end
      if (b[30:23] == 8'd0) begin
         eb = 12'sd1 - 12'(lzb - 7'd40);
         mb = 24'({1'b0, b[22:0]} << (lzb - 7'd40));
      end else begin
         eb = 12'(b[30:23]);
         mb = {1'b1, b[22:0]};
      end
      te = ea;
      tm = ma;
      ts = sa;
      if (eb > ea || (eb == ea && mb > ma)) begin
         ea = eb; ma = mb; sa = sb;
         eb = te; mb = tm; sb = ts;
      end
      d     = 12'(ea - eb);
      wa_in = {2'd0, ma, 38'd0};
      wb_in = {2'd0, mb, 38'd0};
      if (d >= 12'd63) begin
         wb_in = 64'd1;
      end else if (d != 12'd0) begin
         wb_in = (wb_in >> d[5:0])
                 | {63'd0, (wb_in & ((64'd1 << d[5:0]) - 64'd1)) != 64'd0};
      end
      s_in   = sa;
      e_in   = ea + 12'sd1;
      sub_in = (sa != sb);
      special_in = 1'b1;
      spec_in    = 32'd0;
      if (f_is_nan(a) || f_is_nan(b)) begin
         spec_in = QNAN_BITS;
      end else if (f_is_inf(a) && f_is_inf(b)) begin
         spec_in = (a[31] == b[31]) ? a : QNAN_BITS;
      end else if (f_is_inf(a)) begin
         spec_in = a;
      end else if (f_is_inf(b)) begin
         spec_in = b;
      end else if (f_is_zero(a) && f_is_zero(b)) begin
         spec_in = {a[31] & b[31], 31'd0};
      end else if (f_is_zero(a)) begin
         spec_in = b;
      end else if (f_is_zero(b)) begin
         spec_in = a;
      end else begin
         special_in = 1'b0;
      end
      lzs = f_lzc64(acc_ff);
      nrm = acc_ff << (lzs - 7'd1);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         special_ff  <= special_in;
         spec_ff     <= spec_in;
         s_ff        <= s_in;
         e_ff        <= e_in;
         wa_ff       <= wa_in;
         wb_ff       <= wb_in;
         sub_ff      <= sub_in;
         // stage 2: add or subtract aligned significands
         special2_ff <= special_ff;
         spec2_ff    <= spec_ff;
         s2_ff       <= s_ff;
         e2_ff       <= e_ff;
         acc_ff      <= sub_ff ? wa_ff - wb_ff : wa_ff + wb_ff;
         // stage 3: normalize and round
         sum_ff      <= special2_ff ? spec2_ff
                        : (acc_ff == 64'd0) ? 32'd0
                        : f_round_pack(s2_ff, e2_ff - 12'(lzs) + 12'sd1, nrm);
      end
   end

   assign sum = sum_ff;

endmodule

@@ rtl/fast_inverse_sqrt_unit.sv @@
// Fast inverse square root: seed 0x5f3759df - (x >>> 1), one Newton step.
// One transaction per cycle is accepted while the pipeline advances; it
// advances whenever the output register is empty or taken, so a stall holds
// every stage. Synchronous active-high reset clears the valid bits only.
// Depends on fisr_pkg, fisr_fmul, fisr_fadd.
module fast_inverse_sqrt_unit
   import fisr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] x_bits
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] result_bits
);

   logic                 advance;
   logic [LATENCY:0]     valid_ff, valid_in;
   logic [31:0]          x_ff;
   logic [31:0]          y_pipe_ff [0:11];
   logic [31:0]          xhalf, t1, t2, t3, r;
   logic [31:0]          y_seed;

   // Whole pipe moves together; hold everything while the last slot stalls.
   // valid_ff[0] goes with x_ff, valid_ff[LATENCY] with the final product.
   assign advance    = !valid_ff[LATENCY] || rsp_tready;
   assign req_tready = advance;
   assign valid_in   = {valid_ff[LATENCY-1:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // Stage 0: register input and form the integer seed.
   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff <= req_tdata;
      end
   end

   assign y_seed = SEED_MAGIC - {x_ff[31], x_ff[31:1]};

   // Carry the seed alongside the float chain.
   always_ff @(posedge clock) begin
      if (advance) begin
         y_pipe_ff[0] <= y_seed;
         for (int i = 1; i < 12; i++) begin
            y_pipe_ff[i] <= y_pipe_ff[i-1];
         end
      end
   end

   // xhalf = 0.5 * x
   fisr_fmul u_mul_half (.clock(clock), .enable(advance),
                         .a(HALF_BITS), .b(x_ff), .product(xhalf));
   // t1 = xhalf * y, seed taken from y_pipe_ff[2]
   fisr_fmul u_mul_t1 (.clock(clock), .enable(advance),
                       .a(xhalf), .b(y_pipe_ff[2]), .product(t1));
   // t2 = t1 * y
   fisr_fmul u_mul_t2 (.clock(clock), .enable(advance),
                       .a(t1), .b(y_pipe_ff[5]), .product(t2));
   // t3 = 1.5 - t2
   fisr_fadd u_add_t3 (.clock(clock), .enable(advance),
                       .a(THREE_HALVES_BITS), .b(t2 ^ 32'h80000000), .sum(t3));
   // r = y * t3
   fisr_fmul u_mul_r (.clock(clock), .enable(advance),
                      .a(y_pipe_ff[11]), .b(t3), .product(r));

   assign rsp_tvalid = valid_ff[LATENCY];
   assign rsp_tdata  = r;

endmodule
